// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define ISP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");

// Check a property on every edge, reset included.
`define ISP_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("%m: check failed");

`endif

// ===== rtl/isp_pkg.sv =====
`default_nettype none
package isp_pkg;

  localparam int SLOT_SPAN   = 16;
  localparam int DIV_STEPS   = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [63:0] STAT_LIMIT = 64'd1000000000000;
  localparam logic [30:0] FRAME_MAX  = 31'h7FFF_FFFF;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] CFG_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_CAP_FROM = 2'd1;
  localparam logic [1:0] CFG_CAP_MAX  = 2'd2;

  typedef enum logic [2:0] {
    ST_STARTED, ST_RESTARTED, ST_RECORDED, ST_IGNORED, ST_CLEARED, ST_DISABLED
  } status_t;

  typedef enum logic [2:0] {
    K_START, K_STOP, K_CLEAR, K_NOP, K_RANGE, K_OFF
  } kind_t;

  typedef enum logic [3:0] {
    BS_IDLE, BS_READ, BS_DECIDE, BS_MUL_LO, BS_MUL_HI, BS_SUM,
    BS_DIV_INIT, BS_DIV, BS_DIV_END, BS_ABS, BS_WRITE
  } back_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic [62:0] ts;
  } cmd_t;

  typedef struct packed {
    logic        armed;
    logic [63:0] start;
    logic [30:0] frame;
    logic [63:0] min;
    logic [63:0] max;
    logic [63:0] mean;
    logic [63:0] dev;
    logic [15:0] ccount;
  } slot_rec_t;

  typedef struct packed {
    logic        enable;
    logic [31:0] cap_from;
    logic [15:0] cap_max;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic slot_rec_t rec_reset();
    slot_rec_t r;
    r.armed  = 1'b0;
    r.start  = '0;
    r.frame  = '0;
    r.min    = STAT_LIMIT;
    r.max    = 64'd0 - STAT_LIMIT;
    r.mean   = '0;
    r.dev    = '0;
    r.ccount = '0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/isp_queue.sv =====
`default_nettype none
module isp_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  isp_pkg::cmd_t     push_data,
  input  wire               pop,
  output isp_pkg::cmd_t     pop_data,
  output isp_pkg::q_stat_t  stat
);
  import isp_pkg::*;

  cmd_t       entry_r [QUEUE_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  assign pop_data   = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'(QUEUE_DEPTH));
  assign stat.empty = (count_r == 2'd0);
endmodule
`default_nettype wire

// ===== rtl/isp_front.sv =====
`default_nettype none
module isp_front #(
  parameter int NUM_SLOTS = 16
) (
  input  wire               enable,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [1:0]        in_tuser,
  input  wire  [71:0]       in_tdata,
  input  isp_pkg::q_stat_t  q_stat,
  output logic              push,
  output isp_pkg::cmd_t     cmd
);
  import isp_pkg::*;

  logic [1:0] opcode;
  logic [3:0] slot;

  assign opcode    = in_tuser[1:0];
  assign slot      = in_tdata[3:0];
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;

  always_comb begin
    cmd.slot = slot;
    cmd.ts   = in_tdata[66:4];
    if (32'(slot) >= NUM_SLOTS) begin
      cmd.kind = K_RANGE;
    end else begin
      unique case (opcode)
        OP_START: cmd.kind = enable ? K_START : K_OFF;
        OP_STOP:  cmd.kind = enable ? K_STOP : K_OFF;
        OP_CLEAR: cmd.kind = K_CLEAR;
        default:  cmd.kind = K_NOP;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/isp_back.sv =====
`default_nettype none
module isp_back #(
  parameter int NUM_SLOTS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  isp_pkg::cfg_t     cfg,
  input  isp_pkg::q_stat_t  q_stat,
  input  isp_pkg::cmd_t     q_data,
  output logic              q_pop,
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [7:0]        out_tuser,
  output logic [367:0]      out_tdata
);
  import isp_pkg::*;

  localparam int DEPTH = (NUM_SLOTS < SLOT_SPAN) ? NUM_SLOTS : SLOT_SPAN;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  back_state_t state_r, state_nxt;

  slot_rec_t   mem [DEPTH];
  slot_rec_t   rd_q;
  logic [DEPTH-1:0] valid_r;

  cmd_t        cmd_r;
  slot_rec_t   rec_r;
  status_t     st_r;
  logic        zero_r, wr_r, clr_r, cap_r, phase_r, neg_r;
  logic [63:0] dur_r, acc_r, addend_r, num_r, quo_r;
  logic [15:0] cidx_r;
  logic [30:0] n_r, nm1_r, rem_r;
  logic [62:0] plo_r;
  logic [31:0] phi_r;
  logic [6:0]  cnt_r;
  logic        out_valid_r;

  logic [IDX_W-1:0] idx;
  slot_rec_t   rec_cur, dec_rec;
  status_t     dec_st;
  logic        dec_zero, dec_wr, dec_clr, dec_long, dec_cap;
  logic [63:0] dec_dur, dur_calc;
  logic [15:0] dec_cidx;
  logic [30:0] n_calc;
  logic        do_out;
  logic [62:0] mul_lo;
  logic [61:0] mul_hi;
  logic [32:0] trial;
  logic [63:0] quot, diff;

  assign idx = cmd_r.slot[IDX_W-1:0];

  always_comb begin
    rec_cur  = valid_r[idx] ? rd_q : rec_reset();
    dur_calc = {1'b0, cmd_r.ts} - rec_cur.start;
    n_calc   = (rec_cur.frame == '0) ? 31'd1 : rec_cur.frame;
    dec_rec  = rec_cur;
    dec_st   = ST_IGNORED;
    dec_zero = 1'b0;
    dec_wr   = 1'b0;
    dec_clr  = 1'b0;
    dec_long = 1'b0;
    dec_dur  = '0;
    dec_cap  = 1'b0;
    dec_cidx = '0;
    unique case (cmd_r.kind)
      K_RANGE: dec_zero = 1'b1;
      K_CLEAR: begin
        dec_rec = rec_reset();
        dec_st  = ST_CLEARED;
        dec_clr = 1'b1;
      end
      K_OFF: dec_st = ST_DISABLED;
      K_START: begin
        dec_st        = rec_cur.armed ? ST_RESTARTED : ST_STARTED;
        dec_rec.armed = 1'b1;
        if (rec_cur.frame != FRAME_MAX) dec_rec.frame = rec_cur.frame + 31'd1;
        dec_rec.start = {1'b0, cmd_r.ts};
        dec_wr        = 1'b1;
      end
      K_STOP: begin
        if (rec_cur.armed) begin
          dec_st        = ST_RECORDED;
          dec_long      = 1'b1;
          dec_wr        = 1'b1;
          dec_dur       = dur_calc;
          dec_rec.armed = 1'b0;
          if ($signed(dur_calc) < $signed(rec_cur.min)) dec_rec.min = dur_calc;
          if ($signed(rec_cur.max) < $signed(dur_calc)) dec_rec.max = dur_calc;
          if (cfg.cap_max != '0 && rec_cur.ccount < cfg.cap_max && !cfg.cap_from[31]
              && rec_cur.frame >= cfg.cap_from[30:0]) begin
            dec_cap        = 1'b1;
            dec_cidx       = rec_cur.ccount;
            dec_rec.ccount = rec_cur.ccount + 16'd1;
          end
        end
      end
      default: dec_st = ST_IGNORED;
    endcase
  end

  assign mul_lo = nm1_r * acc_r[31:0];
  assign mul_hi = nm1_r * acc_r[62:32];
  assign trial  = {1'b0, rem_r, quo_r[63]} - {2'b0, n_r};
  assign quot   = neg_r ? (64'd0 - quo_r) : quo_r;
  assign diff   = dur_r - rec_r.mean;
  assign do_out = (state_r == BS_WRITE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BS_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      BS_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = BS_READ;
        end
      end
      BS_READ:     state_nxt = BS_DECIDE;
      BS_DECIDE:   state_nxt = dec_long ? BS_MUL_LO : BS_WRITE;
      BS_MUL_LO:   state_nxt = BS_MUL_HI;
      BS_MUL_HI:   state_nxt = BS_SUM;
      BS_SUM:      state_nxt = BS_DIV_INIT;
      BS_DIV_INIT: state_nxt = BS_DIV;
      BS_DIV:      if (cnt_r == 7'd1) state_nxt = BS_DIV_END;
      BS_DIV_END:  state_nxt = phase_r ? BS_WRITE : BS_ABS;
      BS_ABS:      state_nxt = BS_MUL_LO;
      BS_WRITE:    if (do_out) state_nxt = BS_IDLE;
      default:     state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BS_IDLE: cmd_r <= q_data;
      BS_DECIDE: begin
        rec_r    <= dec_rec;
        st_r     <= dec_st;
        zero_r   <= dec_zero;
        wr_r     <= dec_wr;
        clr_r    <= dec_clr;
        dur_r    <= dec_dur;
        cap_r    <= dec_cap;
        cidx_r   <= dec_cidx;
        n_r      <= n_calc;
        nm1_r    <= n_calc - 31'd1;
        acc_r    <= rec_cur.mean;
        addend_r <= dur_calc;
        phase_r  <= 1'b0;
      end
      BS_MUL_LO: plo_r <= mul_lo;
      BS_MUL_HI: phi_r <= {acc_r[63] ? nm1_r[0] : 1'b0, 31'd0} + mul_hi[31:0];
      BS_SUM:    num_r <= {1'b0, plo_r} + {phi_r, 32'd0} + addend_r;
      BS_DIV_INIT: begin
        neg_r <= num_r[63];
        quo_r <= num_r[63] ? (64'd0 - num_r) : num_r;
        rem_r <= '0;
        cnt_r <= 7'(DIV_STEPS);
      end
      BS_DIV: begin
        quo_r <= {quo_r[62:0], !trial[32]};
        rem_r <= trial[32] ? {rem_r[29:0], quo_r[63]} : trial[30:0];
        cnt_r <= cnt_r - 7'd1;
      end
      BS_DIV_END: begin
        if (phase_r) rec_r.dev <= quot;
        else         rec_r.mean <= quot;
      end
      BS_ABS: begin
        addend_r <= diff[63] ? (64'd0 - diff) : diff;
        acc_r    <= rec_r.dev;
        phase_r  <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[idx];
    if (do_out && wr_r) mem[idx] <= rec_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_out && wr_r)  valid_r[idx] <= 1'b1;
      if (do_out && clr_r) valid_r[idx] <= 1'b0;
      if (do_out)          out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_out) begin
      out_tuser <= {5'd0, st_r};
      if (zero_r) out_tdata <= '0;
      else out_tdata <= {cidx_r, cap_r, rec_r.frame, rec_r.dev, rec_r.mean,
                         rec_r.max, rec_r.min, dur_r};
    end
  end

  assign out_tvalid = out_valid_r;
endmodule
`default_nettype wire

// ===== rtl/interval_statistics_profiler_top.sv =====
`default_nettype none
// Per-slot interval profiler. Each input beat is a start, stop or clear for one
// profile slot with a microsecond timestamp; each yields one result beat with
// the slot's min, max, running mean and mean deviation. Beats enter a two-entry
// command queue and are then run one at a time; a recorded stop runs two
// bit-serial 64-step divisions by the frame count, which start, clear and
// ignored beats skip.
`include "assert_macros.svh"
module interval_statistics_profiler_top #(
  parameter int NUM_SLOTS = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_addr,
  input  wire  [31:0]  cfg_wdata,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [1:0]   in_tuser,   // opcode
  input  wire  [71:0]  in_tdata,   // profile_id, timestamp
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [7:0]   out_tuser,  // status
  output logic [367:0] out_tdata   // duration, min_duration, max_duration,
                                   // mean_duration, mean_deviation,
                                   // frame_number, captured, capture_index
);
  import isp_pkg::*;

  logic        enable_r;
  logic [31:0] cap_from_r;
  logic [15:0] cap_max_r;
  cfg_t        cfg;
  q_stat_t     q_stat;
  cmd_t        push_cmd, pop_cmd;
  logic        push, pop;
  logic        cap_beat;
  logic [15:0] cap_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      cap_from_r <= '1;
      cap_max_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ENABLE:   enable_r   <= cfg_wdata[0];
        CFG_CAP_FROM: cap_from_r <= cfg_wdata;
        CFG_CAP_MAX:  cap_max_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg.enable   = enable_r;
  assign cfg.cap_from = cap_from_r;
  assign cfg.cap_max  = cap_max_r;

  isp_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .enable    (enable_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (push_cmd)
  );

  isp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .stat      (q_stat)
  );

  isp_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .q_data     (pop_cmd),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  assign cap_beat = out_tvalid && out_tdata[351];
  assign cap_idx  = out_tdata[367:352];

  `ISP_ASSERT_NR(a_reset_out_idle, clk, !rst_n |=> !out_tvalid)
  `ISP_ASSERT(a_full_stalls_input, clk, rst_n, q_stat.full |-> !in_tready)
  `ISP_ASSERT(a_capture_recorded, clk, rst_n, cap_beat |-> (out_tuser[2:0] == ST_RECORDED))
  `ISP_ASSERT(a_capture_in_window, clk, rst_n, cap_beat && $stable(cap_max_r) |-> cap_idx < cap_max_r)
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import isp_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    status_t     status;
    longint      dur;
    longint      min_d;
    longint      max_d;
    longint      mean_d;
    longint      dev_d;
    bit [30:0]   frame;
    bit          cap;
    bit [15:0]   cidx;
  } interval_result_t;

  class interval_scoreboard;
    bit                cfg_en;
    bit [31:0]         cfg_from;
    bit [15:0]         cfg_cmax;
    bit                armed [16];
    longint            t_start [16];
    bit [30:0]         frames [16];
    longint            min_s [16];
    longint            max_s [16];
    longint            mean_s [16];
    longint            dev_s [16];
    bit [15:0]         ccount [16];
    interval_result_t  pending_q [$];
    int                errors;
    int                n_in;
    int                n_out;
    int                n_rec;
    int                n_cap;

    function void clear_slot(int s);
      armed[s] = 0;
      t_start[s] = 0;
      frames[s] = 0;
      min_s[s] = longint'(STAT_LIMIT);
      max_s[s] = -longint'(STAT_LIMIT);
      mean_s[s] = 0;
      dev_s[s] = 0;
      ccount[s] = 0;
    endfunction

    function void init();
      cfg_en = 0;
      cfg_from = 32'hFFFF_FFFF;
      cfg_cmax = 0;
      for (int s = 0; s < 16; s++) clear_slot(s);
    endfunction

    function void set_reg(logic [1:0] addr, logic [31:0] val);
      case (addr)
        CFG_ENABLE:   cfg_en = val[0];
        CFG_CAP_FROM: cfg_from = val;
        CFG_CAP_MAX:  cfg_cmax = val[15:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [1:0] op, logic [3:0] id, logic [62:0] ts);
      interval_result_t r;
      longint nn;
      longint nm1;
      longint diff;
      r.status = ST_IGNORED;
      r.dur = 0;
      r.cap = 0;
      r.cidx = 0;
      n_in++;
      if (op == OP_CLEAR) begin
        clear_slot(id);
        r.status = ST_CLEARED;
      end else if (op == OP_START || op == OP_STOP) begin
        if (!cfg_en) begin
          r.status = ST_DISABLED;
        end else if (op == OP_START) begin
          r.status = armed[id] ? ST_RESTARTED : ST_STARTED;
          armed[id] = 1;
          if (frames[id] != FRAME_MAX) frames[id]++;
          t_start[id] = longint'({1'b0, ts});
        end else if (armed[id]) begin
          nn = (frames[id] == 0) ? 1 : longint'({33'b0, frames[id]});
          nm1 = nn - 1;
          armed[id] = 0;
          r.dur = longint'({1'b0, ts}) - t_start[id];
          if (r.dur < min_s[id]) min_s[id] = r.dur;
          if (max_s[id] < r.dur) max_s[id] = r.dur;
          mean_s[id] = (nm1 * mean_s[id] + r.dur) / nn;
          diff = r.dur - mean_s[id];
          if (diff < 0) diff = -diff;
          dev_s[id] = (nm1 * dev_s[id] + diff) / nn;
          if (cfg_cmax > 0 && ccount[id] < cfg_cmax && !cfg_from[31] &&
              {1'b0, frames[id]} >= cfg_from) begin
            r.cap = 1;
            r.cidx = ccount[id];
            ccount[id]++;
            n_cap++;
          end
          r.status = ST_RECORDED;
          n_rec++;
        end
      end
      r.min_d = min_s[id];
      r.max_d = max_s[id];
      r.mean_d = mean_s[id];
      r.dev_d = dev_s[id];
      r.frame = frames[id];
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(logic [7:0] user, logic [367:0] data);
      interval_result_t e;
      n_out++;
      if (pending_q.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (user[2:0] != e.status) begin
        $error("status exp %0d got %0d", e.status, user[2:0]); errors++;
      end
      if (data[63:0] != e.dur) begin
        $error("duration exp %0d got %0d", e.dur, $signed(data[63:0])); errors++;
      end
      if (data[127:64] != e.min_d) begin
        $error("min_duration exp %0d got %0d", e.min_d, $signed(data[127:64])); errors++;
      end
      if (data[191:128] != e.max_d) begin
        $error("max_duration exp %0d got %0d", e.max_d, $signed(data[191:128])); errors++;
      end
      if (data[255:192] != e.mean_d) begin
        $error("mean_duration exp %0d got %0d", e.mean_d, $signed(data[255:192]));
        errors++;
      end
      if (data[319:256] != e.dev_d) begin
        $error("mean_deviation exp %0d got %0d", e.dev_d, $signed(data[319:256]));
        errors++;
      end
      if (data[350:320] != e.frame) begin
        $error("frame_number exp %0d got %0d", e.frame, data[350:320]); errors++;
      end
      if (data[351] != e.cap) begin
        $error("captured exp %0d got %0d", e.cap, data[351]); errors++;
      end
      if (data[367:352] != e.cidx) begin
        $error("capture_index exp %0d got %0d", e.cidx, data[367:352]); errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [1:0]   in_tuser;   // opcode
  logic [71:0]  in_tdata;   // profile_id, timestamp
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tuser;  // status
  logic [367:0] out_tdata;  // duration, min_duration, max_duration, mean_duration,
                            // mean_deviation, frame_number, captured, capture_index

  interval_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  longint slot_time [16];

  interval_statistics_profiler_top dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("interval_statistics_profiler_top verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata[3:0], in_tdata[66:4]);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    end
  end

  initial begin
    out_tready <= 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_event(logic [1:0] op, logic [3:0] id, logic [62:0] ts);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {5'b0, ts, id};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [31:0] val);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(addr, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [62:0] rand_ts63();
    return 63'({$urandom, $urandom});
  endfunction

  task automatic random_events(int count);
    logic [3:0]  id;
    logic [62:0] ts;
    int          pick;
    for (int i = 0; i < count; i++) begin
      id = 4'($urandom_range(15));
      pick = int'($urandom_range(99));
      if (pick < 75) begin
        ts = 63'(slot_time[id] + longint'($urandom_range(5000)));
        send_event(OP_START, id, ts);
        if ($urandom_range(9) == 0) send_event(OP_START, id, ts + 63'($urandom_range(50)));
        ts = ts + 63'($urandom_range(100000));
        slot_time[id] = longint'({1'b0, ts});
        send_event(OP_STOP, id, ts);
      end else if (pick < 85) begin
        ts = rand_ts63();
        send_event(2'($urandom_range(1)), id, ts);
      end else if (pick < 93) begin
        send_event(OP_CLEAR, id, rand_ts63());
      end else begin
        send_event(OP_SPARE, id, rand_ts63());
      end
    end
  endtask

  initial begin
    sb = new();
    sb.init();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    for (int s = 0; s < 16; s++) slot_time[s] = longint'($urandom_range(1000000));
    rst_n <= 0;
    cfg_we <= 0;
    cfg_addr <= CFG_ENABLE;
    cfg_wdata <= 0;
    in_tvalid <= 0;
    in_tuser <= OP_START;
    in_tdata <= 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_event(OP_START, 4'd3, 63'd100);
    send_event(OP_STOP, 4'd3, 63'd200);
    send_event(OP_CLEAR, 4'd3, 63'd0);
    send_event(OP_SPARE, 4'd3, 63'd0);
    drain();
    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_CAP_FROM, 32'd0);
    write_reg(CFG_CAP_MAX, 32'd2);
    send_event(OP_START, 4'd0, 63'd0);
    send_event(OP_START, 4'd0, 63'd5);
    send_event(OP_STOP, 4'd0, {63{1'b1}});
    send_event(OP_STOP, 4'd0, 63'd7);
    send_event(OP_START, 4'd15, {63{1'b1}});
    send_event(OP_STOP, 4'd15, 63'd0);
    send_event(OP_START, 4'd15, 63'd10);
    send_event(OP_STOP, 4'd15, 63'd10);
    send_event(OP_START, 4'd15, 63'd20);
    send_event(OP_STOP, 4'd15, 63'd1020);
    send_event(OP_SPARE, 4'd15, 63'd0);
    send_event(OP_CLEAR, 4'd15, 63'd0);
    send_event(OP_SPARE, 4'd15, 63'd0);
    drain();

    write_reg(CFG_CAP_MAX, 32'd65535);
    random_events(60);
    send_idle_pct = 85;
    random_events(40);
    send_idle_pct = 0;
    hold_cycles = 3000;
    random_events(40);
    drain();

    write_reg(CFG_CAP_FROM, 32'd3);
    write_reg(CFG_CAP_MAX, 32'd1);
    recv_stall_pct = 85;
    random_events(50);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_events(40);
    drain();

    write_reg(CFG_CAP_FROM, 32'h7FFF_FFFF);
    write_reg(CFG_CAP_MAX, 32'd5);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_events(30);
    drain();

    write_reg(CFG_ENABLE, 32'd0);
    random_events(10);
    drain();

    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_CAP_FROM, 32'hFFFF_FFFF);
    write_reg(CFG_CAP_MAX, 32'd0);
    send_idle_pct = 85;
    recv_stall_pct = 85;
    random_events(40);
    drain();

    $display("covered %0d events, %0d results, %0d recorded intervals, %0d captured",
             sb.n_in, sb.n_out, sb.n_rec, sb.n_cap);
    if (sb.errors == 0) begin
      $display("interval_statistics_profiler_top verification clean");
    end else begin
      $display("interval_statistics_profiler_top verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/isp_pkg.sv
rtl/isp_queue.sv
rtl/isp_front.sv
rtl/isp_back.sv
rtl/interval_statistics_profiler_top.sv
tb/tb.sv
